// File: rtl/core/swb_crc8_pkg.sv
`timescale 1ns / 1ps
// Package for the single-wire bus master: phase and command codes,
// register map, reset values and the CRC-8 byte update. No dependencies.
package swb_crc8_pkg;

  localparam int unsigned TimerBitsDefault = 10;
  localparam int unsigned CfgWidth = 10;
  localparam int unsigned CfgNum = 8;
  localparam int unsigned CfgIdxWidth = 3;

  typedef logic [CfgWidth-1:0] cfg_word_t;
  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgResetLow = 3'd0;
  localparam cfg_idx_t CfgPresenceWait = 3'd1;
  localparam cfg_idx_t CfgResetRecover = 3'd2;
  localparam cfg_idx_t CfgWriteInit = 3'd3;
  localparam cfg_idx_t CfgWriteSlot = 3'd4;
  localparam cfg_idx_t CfgReadInit = 3'd5;
  localparam cfg_idx_t CfgReadSample = 3'd6;
  localparam cfg_idx_t CfgReadRecover = 3'd7;

  localparam cfg_word_t CfgResetVals [CfgNum] = '{
    10'd500, 10'd80, 10'd500, 10'd8, 10'd80, 10'd5, 10'd24, 10'd40
  };

  localparam logic [7:0] CrcPoly = 8'h8C;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RST_LOW   = 3'd1,
    PH_RST_WAIT  = 3'd2,
    PH_RST_REC   = 3'd3,
    PH_SLOT_INIT = 3'd4,
    PH_SLOT_MID  = 3'd5,
    PH_SLOT_REC  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Reflected CRC-8, LSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data_in);
    logic [7:0] crc;
    logic [7:0] data;
    logic       mix;
    crc  = crc_in;
    data = data_in;
    for (int k = 0; k < 8; k++) begin
      mix  = crc[0] ^ data[0];
      crc  = crc >> 1;
      if (mix) begin
        crc = crc ^ CrcPoly;
      end
      data = data >> 1;
    end
    return crc;
  endfunction

endpackage

// File: rtl/core/single_wire_bus_master_crc8.sv
`timescale 1ns / 1ps
// Single-wire bus master with running CRC-8 over bytes read.
// Depends on swb_crc8_pkg.
//
// One input word is one microsecond tick; the block takes a word every clock cycle while
// s_axis_tready is high and returns exactly one registered result word per tick. The phase
// sequencer and its tick timer update in a single pass per word, and results wait in a
// two-word output buffer, so s_axis_tready only drops when both entries are full.
// Commands arriving while a command is running (done tick included) are ignored;
// configuration writes take effect at the next phase load.
module single_wire_bus_master_crc8
  import swb_crc8_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TimerBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  // ticks in
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [15:0]            s_axis_tdata,  // action[1:0], write_data[9:2], line_in[10]
  // results out
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // drive_low[0], busy_res[1], done_res[2], rx_data[10:3], presence[11], crc_value[19:12]
  output logic [23:0]            m_axis_tdata
);

  typedef logic [TIMER_BITS-1:0] timer_t;

  cfg_word_t  cfg_q [CfgNum];

  phase_e     phase_q, phase_d;
  timer_t     timer_q, timer_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  op_e        op_q, op_d;
  logic       pres_q, pres_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] rdres_q, rdres_d;
  logic       drive, busy, done, last;

  logic        out_valid_q, skid_valid_q;
  logic [23:0] out_data_q, skid_data_q;
  logic [23:0] res_data;
  logic        in_acc, out_acc;

  op_e        action;
  logic [7:0] wdata;
  logic       line;

  function automatic timer_t load_f(input cfg_word_t v);
    return TIMER_BITS'(v);
  endfunction

  assign action = op_e'(s_axis_tdata[1:0]);
  assign wdata  = s_axis_tdata[9:2];
  assign line   = s_axis_tdata[10];

  assign s_axis_tready = !skid_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = out_valid_q && m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CfgNum; i++) begin
        cfg_q[i] <= CfgResetVals[i];
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    op_d    = op_q;
    pres_d  = pres_q;
    crc_d   = crc_q;
    rdres_d = rdres_q;
    drive   = 1'b0;
    busy    = 1'b0;
    done    = 1'b0;
    last    = 1'b0;

    if (phase_q == PH_IDLE && action != OP_NONE) begin
      op_d  = action;
      bit_d = 3'd0;
      if (action == OP_RESET) begin
        crc_d   = 8'd0;
        phase_d = PH_RST_LOW;
        timer_d = load_f(cfg_q[CfgResetLow]);
      end else begin
        shift_d = (action == OP_WRITE) ? wdata : 8'd0;
        phase_d = PH_SLOT_INIT;
        timer_d = load_f((action == OP_WRITE) ? cfg_q[CfgWriteInit] : cfg_q[CfgReadInit]);
      end
    end

    if (phase_d != PH_IDLE) begin
      busy = 1'b1;
      last = (timer_d <= timer_t'(1));
      if (!last) begin
        timer_d = timer_d - timer_t'(1);
      end
      case (phase_d)
        PH_RST_LOW: begin
          drive = 1'b1;
          if (last) begin
            phase_d = PH_RST_WAIT;
            timer_d = load_f(cfg_q[CfgPresenceWait]);
          end
        end
        PH_RST_WAIT: begin
          if (last) begin
            pres_d  = ~line;
            phase_d = PH_RST_REC;
            timer_d = load_f(cfg_q[CfgResetRecover]);
          end
        end
        PH_RST_REC: begin
          if (last) begin
            phase_d = PH_IDLE;
            timer_d = '0;
            done    = 1'b1;
          end
        end
        PH_SLOT_INIT: begin
          drive = 1'b1;
          if (last) begin
            phase_d = PH_SLOT_MID;
            timer_d = load_f((op_d == OP_WRITE) ? cfg_q[CfgWriteSlot] : cfg_q[CfgReadSample]);
          end
        end
        PH_SLOT_MID: begin
          if (op_d == OP_WRITE) begin
            drive = ~shift_d[bit_d];
            if (last) begin
              phase_d = PH_SLOT_REC;
              timer_d = load_f(cfg_q[CfgWriteInit]);
            end
          end else if (last) begin
            shift_d = {line, shift_d[7:1]};
            phase_d = PH_SLOT_REC;
            timer_d = load_f(cfg_q[CfgReadRecover]);
          end
        end
        PH_SLOT_REC: begin
          if (last) begin
            if (bit_d == 3'd7) begin
              if (op_d == OP_READ) begin
                rdres_d = shift_d;
                crc_d   = crc8_byte(crc_d, shift_d);
              end
              phase_d = PH_IDLE;
              timer_d = '0;
              bit_d   = 3'd0;
              done    = 1'b1;
            end else begin
              bit_d   = bit_d + 3'd1;
              phase_d = PH_SLOT_INIT;
              timer_d = load_f((op_d == OP_WRITE) ? cfg_q[CfgWriteInit] : cfg_q[CfgReadInit]);
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
          timer_d = '0;
          busy    = 1'b0;
        end
      endcase
    end
  end

  assign res_data = {4'd0, crc_d, pres_d, rdres_d, done, busy, drive};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      op_q    <= OP_NONE;
      pres_q  <= 1'b0;
      crc_q   <= 8'd0;
      rdres_q <= 8'd0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      op_q    <= op_d;
      pres_q  <= pres_d;
      crc_q   <= crc_d;
      rdres_q <= rdres_d;
    end
  end

  // two-word output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_acc) begin
        out_valid_q  <= skid_valid_q || in_acc;
        skid_valid_q <= skid_valid_q && in_acc;
      end else if (in_acc) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_acc) begin
      out_data_q <= skid_valid_q ? skid_data_q : res_data;
      if (skid_valid_q && in_acc) begin
        skid_data_q <= res_data;
      end
    end else if (in_acc) begin
      skid_data_q <= res_data;
    end
  end

endmodule
